/* hdl/mm2h_pkg.sv */
// Shared types and constants for the MurmurHash2 32-bit hash block.
// Used by mm2h_front, mm2h_queue, mm2h_back and murmur2_hash_32.
`default_nettype none

package mm2h_pkg;

    // Mixing constants
    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int          MIX_SHIFT   = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;

    // Slave-side tdata: total_length, data_word, valid_bytes, padded to bytes
    localparam int S_TDATA_W = 72;

    // What the back end has to do with one queued beat
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_WORD,
        KIND_TAIL
    } kind_t;

    // One classified beat held in the queue
    typedef struct packed {
        logic        start;       // load the hash from start_hash
        logic [31:0] start_hash;  // seed xor total_length
        kind_t       kind;
        logic [31:0] word;        // masked down to the valid bytes for a tail
        logic        last;
    } item_t;

    // Back-end sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY,
        ST_FIN,
        ST_OUT
    } back_state_t;

endpackage

`default_nettype wire

/* hdl/mm2h_front.sv */
// Front end: accepts input beats, drops beats outside a message, classifies
// the rest and pushes them to the queue. Holds the seed register. Uses mm2h_pkg.
`default_nettype none

module mm2h_front
    import mm2h_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 seed_we,
    input  wire logic [31:0]          seed_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tlast,
    input  wire logic                 s_tuser,
    input  wire logic                 q_full,
    output logic                      q_push,
    output item_t                     q_item
);

    logic [31:0] seed_reg;
    logic        in_msg_reg;
    logic        in_msg_next;
    logic        beat;
    logic        keep;
    logic [31:0] total_length;
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic [31:0] tail_mask;

    // Field unpacking
    assign total_length = s_tdata[31:0];
    assign data_word    = s_tdata[63:32];
    assign valid_bytes  = s_tdata[66:64];

    assign s_tready = !q_full;
    assign beat     = s_tvalid && s_tready;
    assign keep     = s_tuser || in_msg_reg;
    assign q_push   = beat && keep;

    // Message tracking: a first beat opens, a last beat closes
    always_comb
    begin
        in_msg_next = in_msg_reg;
        if (beat && keep)
        begin
            in_msg_next = !s_tlast;
        end
    end

    // Tail byte mask
    always_comb
    begin
        case (valid_bytes)
            3'd1:    tail_mask = 32'h0000_00ff;
            3'd2:    tail_mask = 32'h0000_ffff;
            3'd3:    tail_mask = 32'h00ff_ffff;
            default: tail_mask = 32'hffff_ffff;
        endcase
    end

    // Classification
    always_comb
    begin
        q_item.start      = s_tuser;
        q_item.start_hash = seed_reg ^ total_length;
        q_item.word       = data_word & tail_mask;
        q_item.last       = s_tlast;
        if (valid_bytes[2])
        begin
            q_item.kind = KIND_WORD;
        end
        else if (valid_bytes != 3'd0)
        begin
            q_item.kind = KIND_TAIL;
        end
        else
        begin
            q_item.kind = KIND_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg   <= '0;
            in_msg_reg <= 1'b0;
        end
        else
        begin
            in_msg_reg <= in_msg_next;
            if (seed_we)
            begin
                seed_reg <= seed_wdata;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/mm2h_queue.sv */
// Short FIFO of classified beats between front end and back end.
// Uses mm2h_pkg for the item type.
`default_nettype none

module mm2h_queue
    import mm2h_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    output logic       full,
    input  wire logic  pop,
    output logic       not_empty,
    output item_t      head
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             mem [DEPTH];
    logic [IDX_W-1:0]  wr_ptr_reg;
    logic [IDX_W-1:0]  wr_ptr_next;
    logic [IDX_W-1:0]  rd_ptr_reg;
    logic [IDX_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue pushed while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue popped while empty");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a push");
`endif

endmodule

`default_nettype wire

/* hdl/mm2h_back.sv */
// Back end: sequencer that mixes queued beats into the running hash,
// applies the final avalanche and holds the output register. Uses mm2h_pkg.
`default_nettype none

module mm2h_back
    import mm2h_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire item_t       q_item,
    output logic             q_pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata
);

    back_state_t state_reg;
    back_state_t state_next;
    logic [31:0] hash_reg;
    logic [31:0] hash_next;
    logic [31:0] k_reg;
    logic [31:0] k_next;
    logic [31:0] hm_reg;
    logic [31:0] hm_next;
    logic [31:0] fin_reg;
    logic [31:0] fin_next;
    logic        last_reg;
    logic        last_next;
    logic [31:0] out_reg;
    logic        out_valid_reg;
    logic        out_free;
    logic        out_load;
    logic [31:0] h_base;
    logic [31:0] key_mix;
    logic [31:0] fin_mix;

    assign out_free = !out_valid_reg || m_tready;
    assign h_base   = q_item.start ? q_item.start_hash : hash_reg;
    assign key_mix  = k_reg ^ (k_reg >> MIX_SHIFT);
    assign fin_mix  = hash_reg ^ (hash_reg >> FIN_SHIFT_A);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.kind == KIND_WORD)
                    begin
                        state_next = ST_KEY;
                    end
                    else if (q_item.last)
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_KEY:
            begin
                state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_FIN:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath; one multiply per path
    always_comb
    begin
        q_pop     = 1'b0;
        out_load  = 1'b0;
        hash_next = hash_reg;
        k_next    = k_reg;
        hm_next   = hm_reg;
        fin_next  = fin_reg;
        last_next = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    last_next = q_item.last;
                    case (q_item.kind)
                        KIND_WORD:
                        begin
                            k_next  = q_item.word * MIX_MUL;
                            hm_next = h_base * MIX_MUL;
                        end
                        KIND_TAIL:
                        begin
                            hash_next = (h_base ^ q_item.word) * MIX_MUL;
                        end
                        default:
                        begin
                            hash_next = h_base;
                        end
                    endcase
                end
            end
            ST_KEY:
            begin
                hash_next = hm_reg ^ (key_mix * MIX_MUL);
            end
            ST_FIN:
            begin
                fin_next = fin_mix * MIX_MUL;
            end
            ST_OUT:
            begin
                out_load = out_free;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            hash_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            hash_reg  <= hash_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        hm_reg   <= hm_next;
        fin_reg  <= fin_next;
        last_reg <= last_next;
        if (out_load)
        begin
            out_reg <= fin_reg ^ (fin_reg >> FIN_SHIFT_B);
        end
    end

`ifndef NO_ASSERTIONS
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_IDLE))
        else $error("queue popped outside idle");
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_free) |=> (m_tvalid && state_reg == ST_IDLE))
        else $error("finished hash not loaded into output register");
    a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |=> (state_reg == ST_OUT))
        else $error("avalanche step not followed by output step");
`endif

endmodule

`default_nettype wire

/* hdl/murmur2_hash_32.sv */
// MurmurHash2 32-bit block: top level joining front end, queue and back end.
// Depends on mm2h_pkg, mm2h_front, mm2h_queue and mm2h_back.
//
// Usage:
//   Input stream (s_*): one beat per message word. s_tuser marks the first
//   beat, s_tlast the last. s_tdata carries total_length, data_word and
//   valid_bytes. Beats with s_tuser low outside a message are dropped.
//   Output stream (m_*): one beat per message, the finished hash.
//   seed_we/seed_wdata load the seed; write it only while the block is idle.
// Sequencing:
//   The back end takes a full word through ST_IDLE and ST_KEY, a tail or empty
//   beat through ST_IDLE alone, and adds ST_FIN (avalanche) and ST_OUT (output
//   load) on a last beat; the two dependent key-mix multiplies need ST_KEY. The
//   hash goes from ST_OUT into the output register that drives m_tvalid. A
//   QUEUE_DEPTH-entry queue lets the input keep taking beats.
// Reset clears the seed, message state, queue and output valid.
// When m_tready is low the finished hash waits in the output register, the
// back end stops, the queue fills and s_tready falls.
`default_nettype none

module murmur2_hash_32
    import mm2h_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 seed_we,
    input  wire logic [31:0]          seed_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // total_length, data_word, valid_bytes
    input  wire logic                 s_tlast,   // last
    input  wire logic                 s_tuser,   // first
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [31:0]               m_tdata    // hash
);

    logic  q_full;
    logic  q_push;
    item_t q_in;
    logic  q_pop;
    logic  q_valid;
    item_t q_head;

    mm2h_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_we    (seed_we),
        .seed_wdata (seed_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (q_in)
    );

    mm2h_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    mm2h_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
